// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers used by the envelope bank back end
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property holds on every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rst, prop, msg)
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

// ----- src/aeb_pkg.sv -----
// ----------------------------------------------------------------------------
// aeb_pkg
// Types and constants of the ADSR envelope bank
// ----------------------------------------------------------------------------
package aeb_pkg;

  // voice count and widths
  localparam int VOICES  = 48;
  localparam int VOICE_W = 6;
  localparam int ADDR_W  = (VOICES > 1) ? $clog2(VOICES) : 1;

  // level and rate constants
  localparam logic [14:0] LEVEL_MAX = 15'h7fff;
  localparam logic [14:0] EXPO_KNEE = 15'h6000;
  localparam logic [15:0] RATE_FULL = 16'h8000;
  localparam logic [4:0]  SHIFT_KNEE = 5'd11;
  localparam logic [4:0]  SHIFT_MID  = 5'd10;

  typedef enum logic [1:0] {
    FN_TICK    = 2'd0,
    FN_KEY_ON  = 2'd1,
    FN_KEY_OFF = 2'd2,
    FN_STOP    = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    PH_ATTACK  = 3'd0,
    PH_DECAY   = 3'd1,
    PH_SUSTAIN = 3'd2,
    PH_RELEASE = 3'd3,
    PH_STOPPED = 3'd4
  } phase_t;

  // input item as seen on the ports
  typedef struct packed {
    logic [1:0]         func;
    logic [VOICE_W-1:0] voice;
    logic [15:0]        attack_decay_word;
    logic [15:0]        sustain_release_word;
  } in_item_t;

  // result item as seen on the ports
  typedef struct packed {
    logic [VOICE_W-1:0] voice_out;
    logic [14:0]        level;
    logic [2:0]         phase;
    logic               running;
    logic               finished;
  } result_t;

  // classified command handed from front to back
  typedef struct packed {
    func_t              func;
    logic               in_range;
    logic [ADDR_W-1:0]  addr;
    logic [VOICE_W-1:0] voice;
    logic [15:0]        ad;
    logic [15:0]        sr;
  } cmd_t;

  // per-voice envelope state
  typedef struct packed {
    logic [14:0] level;
    phase_t      phase;
    logic [15:0] counter;
    logic        running;
    logic [15:0] ad;
    logic [15:0] sr;
  } voice_state_t;

  // command channel between front and back
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_chan_t;

endpackage

// ----- src/adsr_envelope_bank_top.sv -----
// ----------------------------------------------------------------------------
// adsr_envelope_bank_top
// Throughput: one command per cycle unless a full result queue stalls,
//   also on the same voice back to back, set by the single read and write
//   port of the voice state store.
// Reset: synchronous; clears both queues and all voice valid bits, so every
//   voice reads as level 0, attack, idle, with zero envelope words.
// ----------------------------------------------------------------------------
module adsr_envelope_bank_top
  import aeb_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  output logic     full,
  input  in_item_t item,
  input  logic     pop,
  output logic     empty,
  output result_t  result
);

  cmd_chan_t chan;
  logic      ready;

  // command intake and queue
  aeb_front u_front (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .full  (full),
    .item  (item),
    .chan  (chan),
    .ready (ready)
  );

  // state update and result queue
  aeb_back u_back (
    .clk    (clk),
    .rst    (rst),
    .chan   (chan),
    .ready  (ready),
    .pop    (pop),
    .empty  (empty),
    .result (result)
  );

endmodule

// ----- src/aeb_front.sv -----
// ----------------------------------------------------------------------------
// aeb_front
// Accepts commands, classifies voice range and queues them for the back end
// ----------------------------------------------------------------------------
module aeb_front
  import aeb_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  output logic      full,
  input  in_item_t  item,
  output cmd_chan_t chan,
  input  logic      ready
);

  cmd_t        slot [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        enq;
  logic        deq;
  cmd_t        classified;

  // classify the incoming item
  always_comb begin
    classified.func     = func_t'(item.func);
    classified.in_range = (int'(item.voice) < VOICES);
    classified.addr     = classified.in_range ? item.voice[ADDR_W-1:0] : '0;
    classified.voice    = item.voice;
    classified.ad       = item.attack_decay_word;
    classified.sr       = item.sustain_release_word;
  end

  assign full       = (count == 2'd2);
  assign enq        = push && !full;
  assign chan.valid = (count != 2'd0);
  assign chan.cmd   = slot[rd_ptr];
  assign deq        = chan.valid && ready;

  // queue storage
  always_ff @(posedge clk) begin
    if (enq) begin
      slot[wr_ptr] <= classified;
    end
  end

  // queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (enq) begin
        wr_ptr <= !wr_ptr;
      end
      if (deq) begin
        rd_ptr <= !rd_ptr;
      end
      unique case ({enq, deq})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- src/aeb_back.sv -----
// ----------------------------------------------------------------------------
// aeb_back
// Reads voice state, applies one command per cycle unless a full result queue stalls, and queues the results
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module aeb_back
  import aeb_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cmd_chan_t chan,
  output logic      ready,
  input  logic      pop,
  output logic      empty,
  output result_t   result
);

  // state store with per-entry valid bits
  voice_state_t      mem [VOICES];
  logic [VOICES-1:0] vld;
  voice_state_t      rdata;
  logic              rvld;

  // execute stage
  logic              s1_valid;
  cmd_t              s1_cmd;
  logic              issue;
  logic              commit;

  // last write, for same-voice forwarding
  logic              lw_valid;
  logic [ADDR_W-1:0] lw_addr;
  voice_state_t      lw_data;

  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  voice_state_t      cur;
  voice_state_t      ticked;
  voice_state_t      nxt;
  result_t           res;

  // rate terms
  logic               decr;
  logic               expo;
  logic [4:0]         shift;
  logic signed [4:0]  step;
  logic [15:0]        target;
  logic               inf;
  logic [3:0]         lsh;
  logic [4:0]         csh;
  logic signed [16:0] linc_base;
  logic signed [16:0] linc;
  logic [15:0]        cinc_base;
  logic [15:0]        cinc;
  logic signed [15:0] lvl_s;
  logic signed [32:0] prod;
  logic [16:0]        cnt;
  logic signed [17:0] sum;
  logic [14:0]        lvl_new;
  logic               done;
  phase_t             ph_new;

  // output queue
  result_t           oq [2];
  logic              oq_wr;
  logic              oq_rd;
  logic [1:0]        oq_count;
  logic              pop_ok;

  assign pop_ok = pop && !empty;
  assign commit = s1_valid && ((oq_count != 2'd2) || pop_ok);
  assign ready  = !s1_valid || commit;
  assign issue  = chan.valid && ready;
  assign wr_en  = commit && s1_cmd.in_range;
  assign wr_addr = s1_cmd.addr;

  // memory write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= nxt;
    end
    if (issue) begin
      rdata <= mem[chan.cmd.addr];
    end
  end

  // valid bits, read valid and last-write record
  always_ff @(posedge clk) begin
    if (rst) begin
      vld      <= '0;
      rvld     <= 1'b0;
      lw_valid <= 1'b0;
    end else begin
      if (wr_en) begin
        vld[wr_addr] <= 1'b1;
        lw_valid     <= 1'b1;
      end
      if (issue) begin
        rvld <= vld[chan.cmd.addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      lw_addr <= wr_addr;
      lw_data <= nxt;
    end
  end

  // execute stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (issue) begin
      s1_valid <= 1'b1;
    end else if (commit) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_cmd <= chan.cmd;
    end
  end

  // current state: forwarded, stored or reset value
  always_comb begin
    if (lw_valid && (lw_addr == s1_cmd.addr)) begin
      cur = lw_data;
    end else if (rvld) begin
      cur = rdata;
    end else begin
      cur = '0;
    end
  end

  // phase parameters from the stored words
  always_comb begin
    unique case (cur.phase)
      PH_ATTACK: begin
        decr   = 1'b0;
        expo   = cur.ad[15];
        shift  = cur.ad[14:10];
        step   = 5'sd7 - signed'({3'b000, cur.ad[9:8]});
        target = {1'b0, LEVEL_MAX};
        inf    = &cur.ad[14:8];
      end
      PH_DECAY: begin
        decr   = 1'b1;
        expo   = 1'b1;
        shift  = {1'b0, cur.ad[7:4]};
        step   = -5'sd8;
        target = ({12'd0, cur.ad[3:0]} + 16'd1) << 11;
        inf    = &cur.ad[7:4];
      end
      PH_SUSTAIN: begin
        decr   = cur.sr[14];
        expo   = cur.sr[15];
        shift  = cur.sr[12:8];
        step   = cur.sr[14] ? (signed'({3'b000, cur.sr[7:6]}) - 5'sd8)
                            : (5'sd7 - signed'({3'b000, cur.sr[7:6]}));
        target = 16'd0;
        inf    = &cur.sr[12:6];
      end
      default: begin
        decr   = 1'b1;
        expo   = cur.sr[5];
        shift  = cur.sr[4:0];
        step   = -5'sd8;
        target = 16'd0;
        inf    = &cur.sr[4:0];
      end
    endcase
  end

  // base increments from the shift
  always_comb begin
    lsh       = (shift < SHIFT_KNEE) ? 4'(SHIFT_KNEE - shift) : 4'd0;
    csh       = (shift > SHIFT_KNEE) ? (shift - SHIFT_KNEE) : 5'd0;
    linc_base = 17'(step) <<< lsh;
    cinc_base = RATE_FULL >> csh;
    lvl_s     = signed'({1'b0, cur.level});
    prod      = linc_base * lvl_s;
  end

  // exponential adjustments and infinite rate
  always_comb begin
    linc = linc_base;
    cinc = cinc_base;
    if (expo && !decr && (cur.level >= EXPO_KNEE)) begin
      if (shift < SHIFT_MID) begin
        linc = linc_base >>> 2;
      end else if (shift >= SHIFT_KNEE) begin
        cinc = cinc_base >> 2;
      end else begin
        cinc = cinc_base >> 1;
        linc = linc_base >>> 1;
      end
    end else if (expo && decr) begin
      linc = prod[31:15];
    end
    if (!inf && (cinc == 16'd0)) begin
      cinc = 16'd1;
    end
  end

  // counter, level step with clamp, phase advance
  always_comb begin
    cnt = {1'b0, cur.counter} + {1'b0, cinc};
    sum = signed'({3'b000, cur.level}) + 18'(linc);
    lvl_new = cur.level;
    if (cnt[15]) begin
      if (sum < 0) begin
        lvl_new = '0;
      end else if (sum > signed'({3'b000, LEVEL_MAX})) begin
        lvl_new = LEVEL_MAX;
      end else begin
        lvl_new = sum[14:0];
      end
    end
    done = decr ? ({1'b0, lvl_new} <= target) : ({1'b0, lvl_new} >= target);
    ph_new = cur.phase;
    if ((cur.phase != PH_SUSTAIN) && done) begin
      ph_new = (cur.phase >= PH_RELEASE) ? PH_STOPPED : phase_t'(cur.phase + 3'd1);
    end
    ticked         = cur;
    ticked.level   = lvl_new;
    ticked.counter = cnt[15] ? 16'd0 : cnt[15:0];
    ticked.phase   = ph_new;
    if ((cur.phase != PH_SUSTAIN) && (ph_new > PH_RELEASE)) begin
      ticked.running = 1'b0;
    end
  end

  // command dispatch
  always_comb begin
    nxt = cur;
    unique case (s1_cmd.func)
      FN_TICK: begin
        if (cur.running) begin
          nxt = ticked;
        end
      end
      FN_KEY_ON: begin
        nxt.ad      = s1_cmd.ad;
        nxt.sr      = s1_cmd.sr;
        nxt.level   = '0;
        nxt.counter = '0;
        nxt.phase   = PH_ATTACK;
        nxt.running = 1'b1;
      end
      FN_KEY_OFF: begin
        if (cur.phase < PH_RELEASE) begin
          nxt.phase = PH_RELEASE;
        end
      end
      FN_STOP: begin
        nxt.level   = '0;
        nxt.phase   = PH_STOPPED;
        nxt.running = 1'b0;
      end
    endcase
  end

  // result formatting
  always_comb begin
    res.voice_out = s1_cmd.voice;
    if (s1_cmd.in_range) begin
      res.level    = nxt.level;
      res.phase    = nxt.phase;
      res.running  = nxt.running;
      res.finished = (nxt.level == '0) && (nxt.phase != PH_ATTACK);
    end else begin
      res.level    = '0;
      res.phase    = PH_STOPPED;
      res.running  = 1'b0;
      res.finished = 1'b1;
    end
  end

  // output queue storage
  always_ff @(posedge clk) begin
    if (commit) begin
      oq[oq_wr] <= res;
    end
  end

  // output queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      oq_wr    <= 1'b0;
      oq_rd    <= 1'b0;
      oq_count <= 2'd0;
    end else begin
      if (commit) begin
        oq_wr <= !oq_wr;
      end
      if (pop_ok) begin
        oq_rd <= !oq_rd;
      end
      unique case ({commit, pop_ok})
        2'b10:   oq_count <= oq_count + 2'd1;
        2'b01:   oq_count <= oq_count - 2'd1;
        default: oq_count <= oq_count;
      endcase
    end
  end

  assign empty  = (oq_count == 2'd0);
  assign result = oq[oq_rd];

  // a stalled command keeps its place and contents
  `ASSERT_NEXT(a_s1_hold, clk, rst, s1_valid && !commit, s1_valid && $stable(s1_cmd), "stalled command lost")
  // every committed write marks its entry valid
  `ASSERT_NEXT(a_wr_valid, clk, rst, wr_en, vld[$past(wr_addr)], "write did not set valid bit")
  // a running voice is never reported as stopped
  `ASSERT_IMPLIES(a_run_phase, clk, rst, !empty && result.running, result.phase != PH_STOPPED, "running voice in stopped phase")

endmodule

// ----- sim/tb_adsr_envelope_bank_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_adsr_envelope_bank_top
// Drives envelope commands into the bank and checks every returned voice
// envelope against a cycle-free per-voice predictor kept in the testbench.
// Directed cases first, then well-formed key-on / tick / key-off / stop sequences
// over a small set of voices, then unconstrained command noise.
// ----------------------------------------------------------------------------
module tb_adsr_envelope_bank_top;
  import aeb_pkg::*;

  // cycles without any transfer before the run is declared hung; the slowest
  // correct stretch is a sender gap or a receiver stall
  localparam int STALL_LIMIT = 2000;

  typedef enum {POP_ALWAYS, POP_COIN, POP_PATTERN} pop_mode_t;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     push = 1'b0;
  logic     full;
  in_item_t item = '0;
  logic     pop = 1'b0;
  logic     empty;
  result_t  result;

  // predicted per-voice envelope state
  logic [14:0] env_lvl [VOICES];
  phase_t      env_ph  [VOICES];
  logic [15:0] env_cnt [VOICES];
  logic        env_run [VOICES];
  logic [15:0] ad_word [VOICES];
  logic [15:0] sr_word [VOICES];

  // sequence bookkeeping per voice
  int hold_ticks [VOICES];
  int env_age    [VOICES];

  result_t   expected_envelopes[$];
  result_t   want;
  int        errors = 0;
  int        burst_left = 0;
  int        stall_cycles = 0;
  pop_mode_t pop_mode = POP_ALWAYS;
  int        pop_mode_left = 0;
  int        pop_on = 1;
  int        pop_off = 1;
  int        pop_phase = 0;

  adsr_envelope_bank_top uut (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .item   (item),
    .pop    (pop),
    .empty  (empty),
    .result (result)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // one rate step of a running voice
  task automatic advance_envelope(input int v);
    logic        decr, expo, inf;
    logic [15:0] ad, sr;
    int unsigned shift, cinc, cnt;
    int          step, target, lvl, linc;
    phase_t      ph;
    ph  = env_ph[v];
    ad  = ad_word[v];
    sr  = sr_word[v];
    lvl = int'(env_lvl[v]);
    case (ph)
      PH_ATTACK: begin
        decr   = 1'b0;
        expo   = ad[15];
        shift  = 32'(ad[14:10]);
        step   = 7 - int'(ad[9:8]);
        target = int'(LEVEL_MAX);
        inf    = &ad[14:8];
      end
      PH_DECAY: begin
        decr   = 1'b1;
        expo   = 1'b1;
        shift  = 32'(ad[7:4]);
        step   = -8;
        target = (int'(ad[3:0]) + 1) << 11;
        inf    = &ad[7:4];
      end
      PH_SUSTAIN: begin
        decr   = sr[14];
        expo   = sr[15];
        shift  = 32'(sr[12:8]);
        step   = 7 - int'(sr[7:6]);
        target = 0;
        inf    = &sr[12:6];
        if (decr) begin
          step = -step - 1;
        end
      end
      default: begin
        decr   = 1'b1;
        expo   = sr[5];
        shift  = 32'(sr[4:0]);
        step   = -8;
        target = 0;
        inf    = &sr[4:0];
      end
    endcase

    // counter and level increments from the shift
    cinc = 32'h8000 >> ((shift > 11) ? shift - 11 : 0);
    linc = step * (1 << ((shift < 11) ? 11 - shift : 0));

    // exponential slowdown above the knee, or level-scaled decrease
    if (expo && !decr && lvl >= int'(EXPO_KNEE)) begin
      if (shift < 10) begin
        linc = linc >>> 2;
      end else if (shift >= 11) begin
        cinc = cinc >> 2;
      end else begin
        cinc = cinc >> 1;
        linc = linc >>> 1;
      end
    end else if (expo && decr) begin
      linc = (linc * lvl) >>> 15;
    end

    if (!inf && cinc < 1) begin
      cinc = 1;
    end
    cnt = int'(env_cnt[v]) + cinc;
    if (cnt[15]) begin
      cnt = 0;
      lvl = lvl + linc;
      if (lvl < 0) begin
        lvl = 0;
      end
      if (lvl > int'(LEVEL_MAX)) begin
        lvl = int'(LEVEL_MAX);
      end
    end
    env_cnt[v] = cnt[15:0];
    env_lvl[v] = lvl[14:0];

    // sustain only ends by command
    if (ph != PH_SUSTAIN) begin
      if ((!decr && lvl >= target) || (decr && lvl <= target)) begin
        ph = phase_t'(ph + 1);
        env_ph[v] = ph;
      end
      if (ph == PH_STOPPED) begin
        env_run[v] = 1'b0;
      end
    end
  endtask

  // apply one accepted command and return the envelope it should produce
  task automatic apply_command(input in_item_t it, output result_t r);
    int v;
    v = int'(it.voice);
    r.voice_out = it.voice;
    if (v >= VOICES) begin
      r.level    = '0;
      r.phase    = PH_STOPPED;
      r.running  = 1'b0;
      r.finished = 1'b1;
    end else begin
      case (it.func)
        FN_TICK: begin
          if (env_run[v]) begin
            advance_envelope(v);
          end
        end
        FN_KEY_ON: begin
          ad_word[v] = it.attack_decay_word;
          sr_word[v] = it.sustain_release_word;
          env_lvl[v] = '0;
          env_cnt[v] = '0;
          env_ph[v]  = PH_ATTACK;
          env_run[v] = 1'b1;
        end
        FN_KEY_OFF: begin
          if (env_ph[v] < PH_RELEASE) begin
            env_ph[v] = PH_RELEASE;
          end
        end
        default: begin
          env_lvl[v] = '0;
          env_ph[v]  = PH_STOPPED;
          env_run[v] = 1'b0;
        end
      endcase
      r.level    = env_lvl[v];
      r.phase    = env_ph[v];
      r.running  = env_run[v];
      r.finished = (env_lvl[v] == 0) && (env_ph[v] != PH_ATTACK);
    end
  endtask

  function automatic in_item_t make_item(input func_t f, input int v,
                                         input logic [15:0] ad, input logic [15:0] sr);
    in_item_t it;
    it.func                 = f;
    it.voice                = VOICE_W'(v);
    it.attack_decay_word    = ad;
    it.sustain_release_word = sr;
    return it;
  endfunction

  // envelope words mostly at rates that finish within a few hundred ticks
  function automatic logic [15:0] random_attack_decay();
    logic [15:0] w;
    w = 16'($urandom);
    if ($urandom_range(0, 9) != 0) begin
      w[14:10] = 5'($urandom_range(0, 6));
      w[7:4]   = 4'($urandom_range(0, 5));
    end
    return w;
  endfunction

  function automatic logic [15:0] random_sustain_release();
    logic [15:0] w;
    w = 16'($urandom);
    if ($urandom_range(0, 9) != 0) begin
      w[12:8] = 5'($urandom_range(0, 13));
      w[4:0]  = 5'($urandom_range(0, 5));
    end
    return w;
  endfunction

  // send one command in bursts with random gaps, predict on transfer
  task automatic send_command(input in_item_t it);
    result_t r;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) begin
        push <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
    burst_left--;
    push <= 1'b1;
    item <= it;
    do @(posedge clk); while (full);
    apply_command(it, r);
    expected_envelopes.push_back(r);
  endtask

  task automatic tick_voice(input int v);
    send_command(make_item(FN_TICK, v, 16'($urandom), 16'($urandom)));
  endtask

  // idle voices, out-of-range voices, infinite attack, fast envelopes
  task automatic test_directed_cases();
    tick_voice(0);
    // key-off of a voice that never started moves it to release
    send_command(make_item(FN_KEY_OFF, 1, 16'hffff, 16'hffff));
    tick_voice(1);
    // out-of-range voices leave every store alone
    send_command(make_item(FN_KEY_ON, 48, 16'hffff, 16'hffff));
    send_command(make_item(FN_STOP, 63, 16'h0000, 16'h0000));
    // attack rate infinite: level holds
    send_command(make_item(FN_KEY_ON, 2, 16'h7f00, 16'h0000));
    tick_voice(2);
    // linear attack at full rate, decay straight to sustain, fast release
    send_command(make_item(FN_KEY_ON, 3, 16'h000f, 16'h0000));
    repeat (5) tick_voice(3);
    send_command(make_item(FN_KEY_OFF, 3, 16'h0000, 16'h0000));
    repeat (2) tick_voice(3);
    // exponential attack across the knee, rising exponential sustain
    send_command(make_item(FN_KEY_ON, 5, 16'h80ef, 16'h8a00));
    repeat (7) tick_voice(5);
    send_command(make_item(FN_STOP, 5, 16'h0000, 16'h0000));
  endtask

  // well-formed key-on, ticks, key-off, stop over a small set of voices
  task automatic test_envelope_sequences(input int count, input int pool_size);
    int pool [4];
    int v, k, roll;
    for (k = 0; k < 4; k++) begin
      pool[k] = $urandom_range(0, VOICES - 1);
    end
    repeat (count) begin
      if ($urandom_range(0, 99) == 0) begin
        pool[$urandom_range(0, pool_size - 1)] = $urandom_range(0, VOICES - 1);
      end
      v    = pool[$urandom_range(0, pool_size - 1)];
      roll = $urandom_range(0, 99);
      if (!env_run[v] || roll < 1) begin
        send_command(make_item(FN_KEY_ON, v, random_attack_decay(),
                               random_sustain_release()));
        hold_ticks[v] = $urandom_range(2, 40);
        env_age[v]    = 0;
      end else if (roll < 3 || (env_ph[v] == PH_RELEASE && env_age[v] > 900)) begin
        send_command(make_item(FN_STOP, v, 16'($urandom), 16'($urandom)));
      end else if (roll < 5 || (env_ph[v] == PH_SUSTAIN && hold_ticks[v] == 0) ||
                   (env_ph[v] < PH_RELEASE && env_age[v] > 400)) begin
        send_command(make_item(FN_KEY_OFF, v, 16'($urandom), 16'($urandom)));
      end else begin
        if (env_ph[v] == PH_SUSTAIN && hold_ticks[v] > 0) begin
          hold_ticks[v]--;
        end
        env_age[v]++;
        tick_voice(v);
      end
    end
  endtask

  // any command, any voice number, any words
  task automatic test_random_commands(input int count);
    repeat (count) begin
      send_command(make_item(func_t'($urandom_range(0, 3)), $urandom_range(0, 63),
                             16'($urandom), 16'($urandom)));
    end
  endtask

  // receiver stall pattern
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop_mode_left == 0) begin
        pop_mode      = pop_mode_t'($urandom_range(0, 2));
        pop_mode_left = $urandom_range(16, 160);
        pop_on        = $urandom_range(1, 4);
        pop_off       = $urandom_range(1, 5);
        pop_phase     = 0;
      end
      pop_mode_left--;
      pop_phase = (pop_phase + 1) % (pop_on + pop_off);
      case (pop_mode)
        POP_ALWAYS: pop <= 1'b1;
        POP_COIN:   pop <= 1'($urandom_range(0, 1));
        default:    pop <= (pop_phase < pop_on);
      endcase
    end
  end

  task automatic check_field(input string name, input int exp_val, input int got_val);
    if (exp_val != got_val) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d",
               $time, name, exp_val, got_val);
    end
  endtask

  // compare each result transfer with the oldest prediction
  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      if (expected_envelopes.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %p", $time, result);
      end else begin
        want = expected_envelopes.pop_front();
        check_field("voice_out", int'(want.voice_out), int'(result.voice_out));
        check_field("level", int'(want.level), int'(result.level));
        check_field("phase", int'(want.phase), int'(result.phase));
        check_field("running", int'(want.running), int'(result.running));
        check_field("finished", int'(want.finished), int'(result.finished));
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("[adsr_envelope_bank_top] ERROR");
        $finish;
      end
    end
  end

  initial begin
    for (int i = 0; i < VOICES; i++) begin
      env_lvl[i]    = '0;
      env_ph[i]     = PH_ATTACK;
      env_cnt[i]    = '0;
      env_run[i]    = 1'b0;
      ad_word[i]    = '0;
      sr_word[i]    = '0;
      hold_ticks[i] = 0;
      env_age[i]    = 0;
    end
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_directed_cases();
    test_envelope_sequences(1400, 4);
    // one voice only: every command follows one on the same voice
    test_envelope_sequences(200, 1);
    test_random_commands(400);

    push <= 1'b0;
    while (expected_envelopes.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("[adsr_envelope_bank_top] OK");
    end else begin
      $display("[adsr_envelope_bank_top] ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+src
src/aeb_pkg.sv
src/aeb_front.sv
src/aeb_back.sv
src/adsr_envelope_bank_top.sv
sim/tb_adsr_envelope_bank_top.sv
